// ----- rtl/cef_pkg.sv -----
// Shared types, constants and arithmetic helpers of the 3x3 clamped-edge filter.
// No dependencies; the filter module refers to this package by scoped names.
package cef_pkg;

    localparam int MAX_WIDTH    = 1024;
    localparam int MAX_CHANNELS = 4;
    localparam int XW           = $clog2(MAX_WIDTH);      // column index bits
    localparam int WW           = XW + 1;                 // width value bits
    localparam int CHW          = $clog2(MAX_CHANNELS);   // channel index bits
    localparam int FIFO_DEPTH   = 8;
    localparam int FIFO_AW      = $clog2(FIFO_DEPTH);

    // configuration register indexes
    localparam logic [1:0] REG_FILTER_MODE   = 2'd0;
    localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd1;
    localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd2;
    localparam logic [1:0] REG_CHANNEL_COUNT = 2'd3;

    // filter modes
    localparam logic [2:0] MODE_IDENTITY = 3'd0;
    localparam logic [2:0] MODE_EDGE     = 3'd1;
    localparam logic [2:0] MODE_SHARPEN  = 3'd2;
    localparam logic [2:0] MODE_BLUR     = 3'd3;
    localparam logic [2:0] MODE_GAUSSIAN = 3'd4;
    localparam logic [2:0] MODE_EMBOSS   = 3'd5;

    // pipeline operation kinds
    localparam logic [1:0] OP_NONE   = 2'd0;   // results only, no window change
    localparam logic [1:0] OP_SAMPLE = 2'd1;   // insert one sample, update line stores
    localparam logic [1:0] OP_LOAD   = 2'd2;   // shift in a whole stored column

    // floor(n / 18) == (n * RECIP18) >> RECIP18_SHIFT for n < 32768
    localparam int RECIP18       = 7282;
    localparam int RECIP18_SHIFT = 17;
    localparam int EMBOSS_BIAS   = 128;

    typedef logic [7:0]           byte_t;
    typedef logic [31:0]          word_t;
    typedef logic signed [13:0]   acc_t;

    typedef struct packed {
        logic             valid;
        logic [1:0]       top;     // window row used as the top row
        logic [1:0]       left;
        logic [1:0]       mid;
        logic [1:0]       right;
        logic [CHW-1:0]   ch;
        logic             eob;
        logic             eoi;
    } lane_t;

    typedef struct packed {
        byte_t sample;
        logic  eob;
        logic  eoi;
    } result_t;

    localparam logic signed [4:0] KERN [6][9] = '{
        '{ 5'sd0,  5'sd0,  5'sd0,   5'sd0,  5'sd1,  5'sd0,   5'sd0,  5'sd0,  5'sd0},
        '{-5'sd1, -5'sd1, -5'sd1,  -5'sd1,  5'sd8, -5'sd1,  -5'sd1, -5'sd1, -5'sd1},
        '{ 5'sd0, -5'sd1,  5'sd0,  -5'sd1,  5'sd5, -5'sd1,   5'sd0, -5'sd1,  5'sd0},
        '{ 5'sd1,  5'sd1,  5'sd1,   5'sd1,  5'sd1,  5'sd1,   5'sd1,  5'sd1,  5'sd1},
        '{ 5'sd1,  5'sd2,  5'sd1,   5'sd2,  5'sd4,  5'sd2,   5'sd1,  5'sd2,  5'sd1},
        '{-5'sd2, -5'sd1,  5'sd0,  -5'sd1,  5'sd1,  5'sd1,   5'sd0,  5'sd1,  5'sd2}
    };

    // weighted sum of a 3x3 patch, top-left first
    function automatic acc_t conv_acc(input logic [2:0] mode, input byte_t px [9]);
        acc_t acc;
        acc = '0;
        for (int i = 0; i < 9; i++) begin
            acc = acc + 14'(KERN[mode][i] * $signed({1'b0, px[i]}));
        end
        return acc;
    endfunction

    // divide rounding half away from zero, add bias, saturate to a byte
    function automatic byte_t round_sat(input logic [2:0] mode, input acc_t acc);
        logic [12:0]        mag;
        logic [15:0]        num;
        logic [28:0]        prod;
        logic [12:0]        q;
        logic signed [15:0] v;
        mag  = acc[13] ? 13'(-acc) : 13'(acc);
        num  = '0;
        prod = '0;
        unique case (mode)
            MODE_BLUR:
            begin
                num  = {2'b00, mag, 1'b0} + 16'd9;
                prod = 29'(num * 16'(RECIP18));
                q    = 13'(prod >> RECIP18_SHIFT);
            end
            MODE_GAUSSIAN:
            begin
                num = {2'b00, mag, 1'b0} + 16'd16;
                q   = 13'(num >> 5);
            end
            default:
            begin
                q = mag;
            end
        endcase
        v = acc[13] ? -$signed({3'b000, q}) : $signed({3'b000, q});
        if (mode == MODE_EMBOSS) begin
            v = v + 16'(EMBOSS_BIAS);
        end
        if (v < 0) begin
            return 8'd0;
        end
        if (v > 255) begin
            return 8'd255;
        end
        return v[7:0];
    endfunction

endpackage

// ----- rtl/cef_in_if.sv -----
// Input channel of the filter: valid/ready handshake with a request kind and a sample.
// Depends on nothing.
interface cef_in_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] sample_in;

    modport source (output valid, req_type, sample_in, input ready);
    modport sink   (input valid, req_type, sample_in, output ready);
endinterface

// ----- rtl/cef_out_if.sv -----
// Result channel of the filter: valid/ready handshake with a sample and two markers.
// Depends on nothing.
interface cef_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] sample_out;
    logic       end_of_burst;
    logic       end_of_image;

    modport source (output valid, sample_out, end_of_burst, end_of_image, input ready);
    modport sink   (input valid, sample_out, end_of_burst, end_of_image, output ready);
endinterface

// ----- rtl/conv3x3_clamped_edge_filter.sv -----
// 3x3 clamped-edge convolution filter: line stores, window, arithmetic and result queue.
// Depends on cef_pkg, cef_in_if and cef_out_if.
//
// Samples arrive in raster order with channels interleaved; each result is the 3x3
// filtered sample of one channel, lagging the input by one row plus one pixel. The
// block takes one item per clock while it is not stalled: the two line stores are
// memories with a registered read port and a separate write port for the stage 1
// write-back, with a forwarding register covering the back-to-back read-modify-write
// of the channels of one pixel. Results leave through an 8-entry queue at one per
// clock while the output is ready, and a last-column sample gives two results; the
// input stalls when the queue space reserved by items in flight runs out. After the
// final sample of an image the input pauses while column 0 is loaded into the window;
// then one drain request per cycle flushes the last row while the input is not stalled.
module conv3x3_clamped_edge_filter (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_wdata,
    cef_in_if.sink            src,
    cef_out_if.source         dst
);

    // configuration
    logic [2:0]  filter_mode_reg;
    logic [10:0] image_width_reg;
    logic [15:0] image_height_reg;
    logic [2:0]  channel_count_reg;

    // position state
    logic [cef_pkg::XW-1:0]  column_count_reg, column_count_next;
    logic [15:0]             row_count_reg, row_count_next;
    logic [cef_pkg::CHW-1:0] channel_pos_reg, channel_pos_next;
    logic [cef_pkg::WW-1:0]  drain_x_reg, drain_x_next;
    logic [cef_pkg::CHW-1:0] drain_ch_reg, drain_ch_next;
    logic                    primed_reg, primed_next;

    // line stores
    cef_pkg::word_t          above_mem [cef_pkg::MAX_WIDTH];
    cef_pkg::word_t          center_mem [cef_pkg::MAX_WIDTH];
    cef_pkg::word_t          above_q, center_q;
    logic [cef_pkg::XW-1:0]  raddr;

    // stage 1: store data and window update
    logic                    s1_valid_reg, s1_valid_next;
    logic [1:0]              s1_op_reg, s1_op_next;
    logic [cef_pkg::CHW-1:0] s1_ch_reg, s1_ch_next;
    logic [cef_pkg::XW-1:0]  s1_addr_reg, s1_addr_next;
    cef_pkg::byte_t          s1_sample_reg, s1_sample_next;
    cef_pkg::lane_t [1:0]    s1_lanes_reg, s1_lanes_next;
    logic                    fwd_hit_reg;
    cef_pkg::word_t          fwd_above_reg, fwd_center_reg;

    // stage 2 and 3: accumulate, then round
    cef_pkg::lane_t [1:0]    s2_lanes_reg;
    cef_pkg::lane_t [1:0]    s3_lanes_reg;
    cef_pkg::acc_t           s3_acc_reg [2];

    cef_pkg::word_t          win_reg [9];
    cef_pkg::word_t          win_next [9];

    // result queue
    cef_pkg::result_t            fifo_reg [cef_pkg::FIFO_DEPTH];
    logic [cef_pkg::FIFO_AW-1:0] head_reg, tail_reg;
    logic [cef_pkg::FIFO_AW:0]   count_reg, res_reg;
    logic [1:0]                  n_acc, n_push;
    logic                        pop;

    // effective geometry and mode
    logic [2:0]              mode_eff;
    logic [cef_pkg::WW-1:0]  w_eff, wm1, p1;
    logic [15:0]             h_eff;
    logic [2:0]              c_eff, cm1;
    logic [cef_pkg::XW-1:0]  x, p;
    logic [cef_pkg::CHW-1:0] ch_s, chd;
    logic                    complete, accept, prime_go, drain_past, drain_last;

    // stage 1 store words, with forwarding
    cef_pkg::word_t          a_word, m_word, above_wdata, center_wdata;
    cef_pkg::byte_t          a_byte, m_byte;
    logic                    mem_we;

    cef_pkg::acc_t           acc_c [2];
    cef_pkg::byte_t          res_d [2];

    assign mode_eff = (filter_mode_reg > cef_pkg::MODE_EMBOSS) ? cef_pkg::MODE_IDENTITY
                                                               : filter_mode_reg;
    assign w_eff = (image_width_reg == '0) ? cef_pkg::WW'(1) :
                   (image_width_reg > cef_pkg::WW'(cef_pkg::MAX_WIDTH)) ?
                   cef_pkg::WW'(cef_pkg::MAX_WIDTH) : image_width_reg;
    assign h_eff = (image_height_reg == '0) ? 16'd1 : image_height_reg;
    assign c_eff = (channel_count_reg == '0) ? 3'd1 :
                   (channel_count_reg > 3'(cef_pkg::MAX_CHANNELS)) ?
                   3'(cef_pkg::MAX_CHANNELS) : channel_count_reg;
    assign wm1 = w_eff - cef_pkg::WW'(1);
    assign cm1 = c_eff - 3'd1;
    assign x = ({1'b0, column_count_reg} < w_eff) ? column_count_reg : wm1[cef_pkg::XW-1:0];
    assign ch_s = (3'(channel_pos_reg) < c_eff) ? channel_pos_reg : cm1[cef_pkg::CHW-1:0];
    assign chd = (3'(drain_ch_reg) < c_eff) ? drain_ch_reg : cm1[cef_pkg::CHW-1:0];
    assign p = drain_x_reg[cef_pkg::XW-1:0];
    assign p1 = drain_x_reg + cef_pkg::WW'(1);
    assign complete = row_count_reg >= h_eff;
    assign drain_past = drain_x_reg >= w_eff;
    assign drain_last = (chd == cm1[cef_pkg::CHW-1:0]) && (p1 >= w_eff);
    assign prime_go = complete && !primed_reg;

    assign src.ready = (res_reg <= (cef_pkg::FIFO_AW+1)'(cef_pkg::FIFO_DEPTH - 2)) && !prime_go;
    assign accept = src.valid && src.ready;

    // issue: decode the item, advance the counters, start the store read
    always_comb
    begin
        column_count_next = column_count_reg;
        row_count_next    = row_count_reg;
        channel_pos_next  = channel_pos_reg;
        drain_x_next      = drain_x_reg;
        drain_ch_next     = drain_ch_reg;
        primed_next       = primed_reg;
        s1_valid_next     = 1'b0;
        s1_op_next        = cef_pkg::OP_NONE;
        s1_ch_next        = ch_s;
        s1_addr_next      = x;
        s1_sample_next    = src.sample_in;
        s1_lanes_next     = '0;
        n_acc             = 2'd0;
        raddr             = x;
        if (prime_go) begin
            // load column 0 so the first drain sees its centre column
            primed_next   = 1'b1;
            s1_valid_next = 1'b1;
            s1_op_next    = cef_pkg::OP_LOAD;
            raddr         = '0;
        end else if (accept && src.req_type) begin
            if (complete) begin
                if (drain_past) begin
                    column_count_next = '0;
                    row_count_next    = '0;
                    channel_pos_next  = '0;
                    drain_x_next      = '0;
                    drain_ch_next     = '0;
                    primed_next       = 1'b0;
                end else begin
                    n_acc         = 2'd1;
                    s1_valid_next = 1'b1;
                    s1_ch_next    = chd;
                    raddr = (p1 < w_eff) ? p1[cef_pkg::XW-1:0] : wm1[cef_pkg::XW-1:0];
                    // a new pixel shifts the next stored column in
                    s1_op_next = (chd == '0) ? cef_pkg::OP_LOAD : cef_pkg::OP_NONE;
                    s1_lanes_next[0].valid = 1'b1;
                    s1_lanes_next[0].top   = (h_eff == 16'd1) ? 2'd1 : 2'd0;
                    s1_lanes_next[0].left  = (p == '0) ? 2'd1 : 2'd0;
                    s1_lanes_next[0].mid   = 2'd1;
                    s1_lanes_next[0].right = ({1'b0, p} == wm1) ? 2'd1 : 2'd2;
                    s1_lanes_next[0].ch    = chd;
                    s1_lanes_next[0].eob   = 1'b1;
                    s1_lanes_next[0].eoi   = drain_last;
                    if (drain_last) begin
                        column_count_next = '0;
                        row_count_next    = '0;
                        channel_pos_next  = '0;
                        drain_x_next      = '0;
                        drain_ch_next     = '0;
                        primed_next       = 1'b0;
                    end else if (chd == cm1[cef_pkg::CHW-1:0]) begin
                        drain_ch_next = '0;
                        drain_x_next  = p1;
                    end else begin
                        drain_ch_next = chd + cef_pkg::CHW'(1);
                    end
                end
            end
        end else if (accept && !complete) begin
            s1_valid_next = 1'b1;
            s1_op_next    = cef_pkg::OP_SAMPLE;
            if (row_count_reg >= 16'd1) begin
                s1_lanes_next[0].valid = (x != '0);
                s1_lanes_next[0].top   = (row_count_reg == 16'd1) ? 2'd1 : 2'd0;
                s1_lanes_next[0].left  = (x == cef_pkg::XW'(1)) ? 2'd1 : 2'd0;
                s1_lanes_next[0].mid   = 2'd1;
                s1_lanes_next[0].right = 2'd2;
                s1_lanes_next[0].ch    = ch_s;
                s1_lanes_next[1].valid = ({1'b0, x} == wm1);
                s1_lanes_next[1].top   = (row_count_reg == 16'd1) ? 2'd1 : 2'd0;
                s1_lanes_next[1].left  = (x == '0) ? 2'd2 : 2'd1;
                s1_lanes_next[1].mid   = 2'd2;
                s1_lanes_next[1].right = 2'd2;
                s1_lanes_next[1].ch    = ch_s;
                s1_lanes_next[1].eob   = 1'b1;
                s1_lanes_next[0].eob   = !s1_lanes_next[1].valid;
                n_acc = 2'(s1_lanes_next[0].valid) + 2'(s1_lanes_next[1].valid);
            end
            if (ch_s == cm1[cef_pkg::CHW-1:0]) begin
                channel_pos_next = '0;
                if ({1'b0, x} >= wm1) begin
                    column_count_next = '0;
                    row_count_next    = row_count_reg + 16'd1;
                end else begin
                    column_count_next = x + cef_pkg::XW'(1);
                end
            end else begin
                channel_pos_next = ch_s + cef_pkg::CHW'(1);
            end
        end
    end

    // stage 1: merge the store words, update the window, write back
    assign a_word = fwd_hit_reg ? fwd_above_reg : above_q;
    assign m_word = fwd_hit_reg ? fwd_center_reg : center_q;
    assign a_byte = a_word[8*s1_ch_reg +: 8];
    assign m_byte = m_word[8*s1_ch_reg +: 8];
    assign mem_we = s1_valid_reg && (s1_op_reg == cef_pkg::OP_SAMPLE);

    always_comb
    begin
        above_wdata  = a_word;
        center_wdata = m_word;
        above_wdata[8*s1_ch_reg +: 8]  = m_byte;
        center_wdata[8*s1_ch_reg +: 8] = s1_sample_reg;
    end

    always_comb
    begin
        win_next = win_reg;
        if (s1_valid_reg) begin
            unique case (s1_op_reg)
                cef_pkg::OP_SAMPLE:
                begin
                    if (s1_ch_reg == '0) begin
                        for (int r = 0; r < 3; r++) begin
                            win_next[r*3]   = win_reg[r*3+1];
                            win_next[r*3+1] = win_reg[r*3+2];
                        end
                    end
                    win_next[2][8*s1_ch_reg +: 8] = a_byte;
                    win_next[5][8*s1_ch_reg +: 8] = m_byte;
                    win_next[8][8*s1_ch_reg +: 8] = s1_sample_reg;
                end
                cef_pkg::OP_LOAD:
                begin
                    for (int r = 0; r < 3; r++) begin
                        win_next[r*3]   = win_reg[r*3+1];
                        win_next[r*3+1] = win_reg[r*3+2];
                    end
                    // the last row repeats below itself
                    win_next[2] = a_word;
                    win_next[5] = m_word;
                    win_next[8] = m_word;
                end
                default:
                begin
                    win_next = win_reg;
                end
            endcase
        end
    end

    // stage 2: gather each lane's patch and accumulate
    always_comb
    begin
        cef_pkg::byte_t px [9];
        logic [1:0]     rows [3];
        logic [1:0]     cols [3];
        for (int l = 0; l < 2; l++) begin
            rows[0] = s2_lanes_reg[l].top;
            rows[1] = 2'd1;
            rows[2] = 2'd2;
            cols[0] = s2_lanes_reg[l].left;
            cols[1] = s2_lanes_reg[l].mid;
            cols[2] = s2_lanes_reg[l].right;
            for (int r = 0; r < 3; r++) begin
                for (int k = 0; k < 3; k++) begin
                    px[r*3+k] = win_reg[4'(rows[r]) * 4'd3 + 4'(cols[k])]
                                       [8*s2_lanes_reg[l].ch +: 8];
                end
            end
            acc_c[l] = cef_pkg::conv_acc(mode_eff, px);
        end
    end

    // stage 3: round and saturate, then queue
    assign res_d[0] = cef_pkg::round_sat(mode_eff, s3_acc_reg[0]);
    assign res_d[1] = cef_pkg::round_sat(mode_eff, s3_acc_reg[1]);
    assign n_push = 2'(s3_lanes_reg[0].valid) + 2'(s3_lanes_reg[1].valid);
    assign pop = dst.valid && dst.ready;

    assign dst.valid        = count_reg != '0;
    assign dst.sample_out   = fifo_reg[head_reg].sample;
    assign dst.end_of_burst = fifo_reg[head_reg].eob;
    assign dst.end_of_image = fifo_reg[head_reg].eoi;

    always_ff @(posedge clk)
    begin
        above_q  <= above_mem[raddr];
        center_q <= center_mem[raddr];
        if (mem_we) begin
            above_mem[s1_addr_reg]  <= above_wdata;
            center_mem[s1_addr_reg] <= center_wdata;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        s1_op_reg      <= s1_op_next;
        s1_ch_reg      <= s1_ch_next;
        s1_addr_reg    <= s1_addr_next;
        s1_sample_reg  <= s1_sample_next;
        fwd_above_reg  <= above_wdata;
        fwd_center_reg <= center_wdata;
        s3_acc_reg     <= acc_c;
        if (s3_lanes_reg[0].valid) begin
            fifo_reg[tail_reg] <= '{res_d[0], s3_lanes_reg[0].eob, s3_lanes_reg[0].eoi};
        end
        if (s3_lanes_reg[1].valid) begin
            fifo_reg[tail_reg + cef_pkg::FIFO_AW'(s3_lanes_reg[0].valid)] <=
                '{res_d[1], s3_lanes_reg[1].eob, s3_lanes_reg[1].eoi};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            filter_mode_reg   <= cef_pkg::MODE_IDENTITY;
            image_width_reg   <= 11'd640;
            image_height_reg  <= 16'd480;
            channel_count_reg <= 3'd3;
            column_count_reg  <= '0;
            row_count_reg     <= '0;
            channel_pos_reg   <= '0;
            drain_x_reg       <= '0;
            drain_ch_reg      <= '0;
            primed_reg        <= 1'b0;
            s1_valid_reg      <= 1'b0;
            s1_lanes_reg      <= '0;
            s2_lanes_reg      <= '0;
            s3_lanes_reg      <= '0;
            fwd_hit_reg       <= 1'b0;
            head_reg          <= '0;
            tail_reg          <= '0;
            count_reg         <= '0;
            res_reg           <= '0;
            for (int i = 0; i < 9; i++) begin
                win_reg[i] <= '0;
            end
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    cef_pkg::REG_FILTER_MODE:   filter_mode_reg   <= cfg_wdata[2:0];
                    cef_pkg::REG_IMAGE_WIDTH:   image_width_reg   <= cfg_wdata[10:0];
                    cef_pkg::REG_IMAGE_HEIGHT:  image_height_reg  <= cfg_wdata;
                    cef_pkg::REG_CHANNEL_COUNT: channel_count_reg <= cfg_wdata[2:0];
                endcase
            end
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
            channel_pos_reg  <= channel_pos_next;
            drain_x_reg      <= drain_x_next;
            drain_ch_reg     <= drain_ch_next;
            primed_reg       <= primed_next;
            s1_valid_reg     <= s1_valid_next;
            s1_lanes_reg     <= s1_lanes_next;
            s2_lanes_reg     <= s1_valid_reg ? s1_lanes_reg : '0;
            s3_lanes_reg     <= s2_lanes_reg;
            // a write lands on the word being read: hand it over next cycle
            fwd_hit_reg      <= mem_we && (s1_addr_reg == raddr);
            win_reg          <= win_next;
            head_reg         <= head_reg + cef_pkg::FIFO_AW'(pop);
            tail_reg         <= tail_reg + cef_pkg::FIFO_AW'(n_push);
            count_reg        <= count_reg + (cef_pkg::FIFO_AW+1)'(n_push)
                                - (cef_pkg::FIFO_AW+1)'(pop);
            res_reg          <= res_reg + (cef_pkg::FIFO_AW+1)'(n_acc)
                                - (cef_pkg::FIFO_AW+1)'(pop);
        end
    end

    a_res_bound: assert property (@(posedge clk) disable iff (!rst_n)
        res_reg <= (cef_pkg::FIFO_AW+1)'(cef_pkg::FIFO_DEPTH))
        else $error("reserved result slots exceed the queue depth");

    a_count_le_res: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= res_reg)
        else $error("queued results exceed reserved slots");

    a_prime_alone: assert property (@(posedge clk) disable iff (!rst_n)
        prime_go |-> !accept)
        else $error("item transfer during window priming");

    a_lane_order: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_lanes_reg[0].valid && s3_lanes_reg[1].valid) |-> !s3_lanes_reg[0].eob)
        else $error("end of burst marked before the last result of an item");

    a_no_write_when_complete: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && complete) |=> !mem_we)
        else $error("line store written after the image was complete");

endmodule
